// ===== src/mcc_pkg.sv =====
// Shared widths and constants for the minimum coin change block.
package mcc_pkg;

	localparam int MAX_TARGET = 1023;
	localparam int TBL_DEPTH  = MAX_TARGET + 1;
	localparam int AMT_W      = $clog2(TBL_DEPTH);
	localparam int CNT_W      = 11;
	localparam int COIN_W     = 16;
	localparam int TGT_W      = 10;
	localparam int RES_W      = 10;

	localparam logic [CNT_W-1:0] COUNT_INF = '1;

	typedef logic [AMT_W-1:0]  amt_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [COIN_W-1:0] coin_t;
	typedef logic [TGT_W-1:0]  tgt_t;
	typedef logic [RES_W-1:0]  res_t;

	// one more coin on top of a count, held at infinity
	function automatic cnt_t cnt_inc(input cnt_t c);
		cnt_t r;
		r = (c == COUNT_INF) ? COUNT_INF : c + cnt_t'(1);
		return r;
	endfunction

endpackage

// ===== src/mcc_if.sv =====
// Channel interfaces: coin beats in, result beats out, target writes.
interface mcc_coin_if;
	logic                         valid;
	logic                         ready;
	logic [mcc_pkg::COIN_W-1:0]   coin_value;
	logic                         last_coin;

	modport source (output valid, coin_value, last_coin, input ready);
	modport sink   (input valid, coin_value, last_coin, output ready);
endinterface

interface mcc_res_if;
	logic                         valid;
	logic                         ready;
	logic [mcc_pkg::RES_W-1:0]    min_coins;
	logic                         no_solution;

	modport source (output valid, min_coins, no_solution, input ready);
	modport sink   (input valid, min_coins, no_solution, output ready);
endinterface

interface mcc_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [mcc_pkg::TGT_W-1:0]    data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

// ===== src/mcc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mcc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/min_coin_change_dp.sv =====
// Minimum coin change: a table sweep per nonzero or set-opening coin, result after the last coin.
// A nonzero coin, or the first coin of a set, sweeps all 1024 table entries, one per cycle,
//   through the issue stage and the read/write stage.
// A zero coin that is not first skips the sweep; a last coin adds a result read and load.
// Coins are accepted only in idle, so a new coin waits until the previous one is through.
// Reset: control clears, awaiting-first-coin set, target 0; table rebuilt on a set's first coin.
module min_coin_change_dp (
	input  logic        clk,
	input  logic        arst_n,
	mcc_coin_if.sink    coin_in,
	mcc_res_if.source   result_out,
	mcc_cfg_if.sink     cfg
);
	import mcc_pkg::*;

	// sequencer codes
	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SWEEP  = 2'd1;
	localparam logic [1:0] ST_RES_RD = 2'd2;
	localparam logic [1:0] ST_RES_WR = 2'd3;

	localparam amt_t AMT_LAST = amt_t'(MAX_TARGET);

	logic [1:0] state_q;
	logic       awaiting_q;   // next coin opens a new set
	tgt_t       target_q;

	coin_t      coin_q;
	logic       last_q;
	logic       init_q;       // this sweep also rebuilds the table

	// issue side: addresses for amount iss_q
	amt_t       iss_q;
	logic       iss_on_q;

	// stage 1: read data for amount amt_s1 is on the RAM outputs
	amt_t       amt_s1;
	logic       vld_s1;

	cnt_t       fwd_q;        // value written last cycle (amount - 1)

	res_t       res_cnt_q;
	logic       res_none_q;
	logic       res_vld_q;

	// RAM hookup: copy A reads amount - coin, copy B reads the amount itself in a sweep, else the target
	amt_t       rd_a_addr;
	amt_t       rd_b_addr;
	cnt_t       rd_a_data;
	cnt_t       rd_b_data;
	logic       ram_we;
	cnt_t       wr_data;

	logic       coin_acc;
	logic       has_prior;
	cnt_t       prior;
	cnt_t       take;
	cnt_t       old_val;
	logic       sweep_done;
	logic       res_load;     // result register takes a new beat

	assign coin_in.ready = (state_q == ST_IDLE);
	assign coin_acc      = coin_in.valid && coin_in.ready;
	assign cfg.ready     = 1'b1;

	assign rd_a_addr = iss_q - coin_q[AMT_W-1:0];
	assign rd_b_addr = (state_q == ST_SWEEP) ? iss_q : amt_t'(target_q);

	mcc_ram #(.WIDTH(CNT_W), .DEPTH(TBL_DEPTH)) u_tbl_a (
		.clk   (clk),
		.we    (ram_we),
		.waddr (amt_s1),
		.wdata (wr_data),
		.raddr (rd_a_addr),
		.rdata (rd_a_data)
	);

	mcc_ram #(.WIDTH(CNT_W), .DEPTH(TBL_DEPTH)) u_tbl_b (
		.clk   (clk),
		.we    (ram_we),
		.waddr (amt_s1),
		.wdata (wr_data),
		.raddr (rd_b_addr),
		.rdata (rd_b_data)
	);

	// relax step: entry = min(entry, entry[amount - coin] + 1)
	always_comb begin
		// a zero coin relaxes no entry
		has_prior = (coin_q != '0) && ({{(COIN_W-AMT_W){1'b0}}, amt_s1} >= coin_q);
		// a one-cent coin needs the entry written in the previous cycle
		prior     = (coin_q == coin_t'(1)) ? fwd_q : rd_a_data;
		take      = cnt_inc(prior);
		if (init_q) begin
			old_val = (amt_s1 == '0) ? cnt_t'(0) : COUNT_INF;
		end else begin
			old_val = rd_b_data;
		end
		wr_data   = (has_prior && (take < old_val)) ? take : old_val;
	end

	assign ram_we     = vld_s1;
	assign sweep_done = vld_s1 && (amt_s1 == AMT_LAST);
	assign res_load   = (state_q == ST_RES_WR) && (!res_vld_q || result_out.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			target_q <= cfg.data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			awaiting_q <= 1'b1;
			iss_on_q   <= 1'b0;
			vld_s1     <= 1'b0;
			res_vld_q  <= 1'b0;
		end else begin
			if (res_load) begin
				res_vld_q <= 1'b1;
			end else if (result_out.valid && result_out.ready) begin
				res_vld_q <= 1'b0;
			end
			vld_s1 <= iss_on_q;
			if (iss_on_q && (iss_q == AMT_LAST)) begin
				iss_on_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (coin_acc) begin
						awaiting_q <= 1'b0;
						if (coin_in.coin_value != '0 || awaiting_q) begin
							state_q  <= ST_SWEEP;
							iss_on_q <= 1'b1;
						end else if (coin_in.last_coin) begin
							state_q <= ST_RES_RD;
						end
					end
				end
				ST_SWEEP: begin
					if (sweep_done) begin
						state_q <= last_q ? ST_RES_RD : ST_IDLE;
					end
				end
				ST_RES_RD: begin
					state_q <= ST_RES_WR;
				end
				ST_RES_WR: begin
					if (res_load) begin
						awaiting_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (coin_acc) begin
			coin_q <= coin_in.coin_value;
			last_q <= coin_in.last_coin;
			init_q <= awaiting_q;
			iss_q  <= '0;
		end else if (iss_on_q && (iss_q != AMT_LAST)) begin
			iss_q  <= iss_q + amt_t'(1);
		end
		amt_s1 <= iss_q;
		if (vld_s1) begin
			fwd_q <= wr_data;
		end
		if (res_load) begin
			res_none_q <= rd_b_data[CNT_W-1];
			res_cnt_q  <= rd_b_data[CNT_W-1] ? res_t'(0) : rd_b_data[RES_W-1:0];
		end
	end

	assign result_out.valid       = res_vld_q;
	assign result_out.min_coins   = res_cnt_q;
	assign result_out.no_solution = res_none_q;

	// table writes only happen inside a sweep
	a_we_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_SWEEP))
		else $error("table write outside a sweep");

	// relax never raises an entry
	a_no_raise: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (wr_data <= old_val))
		else $error("table entry increased");

	// amount zero always costs zero coins
	a_zero_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && amt_s1 == '0) |-> (wr_data == '0))
		else $error("entry zero not zero");

	// pipeline drains right after the last amount
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		sweep_done |=> (!vld_s1 && !iss_on_q))
		else $error("sweep did not stop");

	// a result reports either a count or no solution, not both
	a_res_form: assert property (@(posedge clk) disable iff (!arst_n)
		(result_out.valid && result_out.no_solution) |-> (result_out.min_coins == '0))
		else $error("count with no-solution flag");

endmodule

// ===== dv/min_coin_change_dp_tb.sv =====
// Self-checking bench for min_coin_change_dp: coin sets driven against a table-based coin count predictor.
module min_coin_change_dp_tb;
	import mcc_pkg::*;

	// covers one coin sweep plus result read; pad generously
	localparam int SETTLE_CYCLES   = 1100;
	localparam int NUM_PHASES      = 12;
	localparam int ITEMS_PER_PHASE = 48;
	// phase where the receiver holds off while coins keep coming
	localparam int HOLD_PHASE      = 5;
	localparam int RX_HOLD_CYCLES  = 5000;
	// hard limit of about five times the slowest run
	localparam int LIMIT_TIME      = 30_000_000;

	typedef struct {
		res_t min_coins;
		logic no_solution;
	} coin_result_t;

	// Predicts one result per coin set; holds the fewest-coins table and target.
	class coin_change_scoreboard;
		cnt_t         best_cnt [0:MAX_TARGET];
		bit           awaiting_first;
		tgt_t         target;
		coin_result_t result_q [$];
		int           errors;
		int           coins_seen;
		int           sets_done;
		int           results_seen;

		function new();
			clear_table();
			awaiting_first = 1;
			target         = '0;
			errors         = 0;
			coins_seen     = 0;
			sets_done      = 0;
			results_seen   = 0;
		endfunction

		function void clear_table();
			best_cnt[0] = '0;
			for (int a = 1; a <= MAX_TARGET; a++)
				best_cnt[a] = COUNT_INF;
		endfunction

		function void set_target(tgt_t t);
			target = t;
		endfunction

		function int pending();
			return result_q.size();
		endfunction

		// accepted coin beat: one ascending sweep per nonzero coin, result on the last coin
		function void note_coin(coin_t coin, logic is_last);
			cnt_t         take;
			cnt_t         count;
			int           c;
			coin_result_t res;
			coins_seen++;
			if (awaiting_first) begin
				clear_table();
				awaiting_first = 0;
			end
			c = int'(coin);
			if (c != 0) begin
				for (int a = c; a <= MAX_TARGET; a++) begin
					take = (best_cnt[a-c] == COUNT_INF) ? COUNT_INF : best_cnt[a-c] + cnt_t'(1);
					if (take < best_cnt[a])
						best_cnt[a] = take;
				end
			end
			if (!is_last)
				return;
			awaiting_first = 1;
			count = best_cnt[target];
			if (count == COUNT_INF || count > cnt_t'(MAX_TARGET)) begin
				res.min_coins   = '0;
				res.no_solution = 1'b1;
			end else begin
				res.min_coins   = res_t'(count);
				res.no_solution = 1'b0;
			end
			result_q.push_back(res);
			sets_done++;
		endfunction

		function void check_result(res_t got_coins, logic got_none);
			coin_result_t want;
			results_seen++;
			if (result_q.size() == 0) begin
				if (errors < 10)
					$display("ERROR: result beat with nothing pending: min_coins=%0d no_solution=%0b",
						got_coins, got_none);
				errors++;
				return;
			end
			want = result_q.pop_front();
			if (got_coins !== want.min_coins || got_none !== want.no_solution) begin
				if (errors < 10)
					$display("ERROR: result %0d: min_coins exp %0d got %0d, no_solution exp %0b got %0b",
						results_seen, want.min_coins, got_coins, want.no_solution, got_none);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	mcc_coin_if coin_if ();
	mcc_res_if  res_if ();
	mcc_cfg_if  cfg_if ();

	min_coin_change_dp u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.coin_in    (coin_if),
		.result_out (res_if),
		.cfg        (cfg_if)
	);

	coin_change_scoreboard sb;

	bit coin_offering;    // coin valid currently held high
	int burst_left;       // coin beats left in the current burst
	int target_writes;
	int rx_hold_req;      // set by stimulus, picked up by the receiver
	int rx_hold_left;
	int rx_mode;
	int rx_mode_left;
	int rx_stall_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#(LIMIT_TIME);
		$display("Some tests failed");
		$finish;
	end

	// Receiver: rotates between always-ready, coin-flip and run-length stalls.
	// A hold request from the stimulus blocks results for a long stretch.
	always @(posedge clk) begin
		if (rx_hold_req != 0) begin
			rx_hold_left = rx_hold_req;
			rx_hold_req  = 0;
		end
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			res_if.ready <= 1'b0;
		end else begin
			if (rx_mode_left == 0) begin
				rx_mode      = $urandom_range(0, 2);
				rx_mode_left = $urandom_range(16, 200);
			end else begin
				rx_mode_left--;
			end
			case (rx_mode)
				0: res_if.ready <= 1'b1;
				1: res_if.ready <= 1'($urandom_range(0, 1));
				default: begin
					if (rx_stall_left > 0) begin
						rx_stall_left--;
						res_if.ready <= 1'b0;
					end else begin
						rx_stall_left = $urandom_range(0, 12);
						res_if.ready <= 1'b1;
					end
				end
			endcase
		end
	end

	// Beat monitor: every handshake sampled at the edge it completes on.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_if.valid && cfg_if.ready)
				sb.set_target(cfg_if.data);
			if (coin_if.valid && coin_if.ready)
				sb.note_coin(coin_if.coin_value, coin_if.last_coin);
			if (res_if.valid && res_if.ready)
				sb.check_result(res_if.min_coins, res_if.no_solution);
		end
	end

	task automatic pause_coins(input int n);
		coin_if.valid <= 1'b0;
		coin_offering = 0;
		repeat (n) @(posedge clk);
	endtask

	// burst/gap pacing after each accepted coin; gap 0 keeps valid high
	task automatic pace();
		int gap;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 8);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0)
				pause_coins(gap);
		end
	endtask

	task automatic send_coin(input coin_t c, input bit is_last);
		coin_if.valid      <= 1'b1;
		coin_if.coin_value <= c;
		coin_if.last_coin  <= is_last;
		coin_offering = 1;
		@(posedge clk);
		while (!coin_if.ready)
			@(posedge clk);
		pace();
	endtask

	// Drop coin valid, wait for all pending results, then let any coin
	// that yields no result finish its sweep.
	task automatic settle_block();
		if (coin_offering)
			pause_coins(1);
		else
			@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_target(input tgt_t t);
		settle_block();
		cfg_if.valid <= 1'b1;
		cfg_if.data  <= t;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		cfg_if.valid <= 1'b0;
		target_writes++;
		@(posedge clk);
	endtask

	// Mostly small coins so results stay interesting; some zero, some
	// beyond the table, some fully random to toggle every bit.
	function automatic coin_t pick_coin(tgt_t tgt);
		int r;
		int hi;
		r  = $urandom_range(0, 99);
		hi = int'(tgt) / 3;
		if (hi < 3)
			hi = 3;
		if (hi > 120)
			hi = 120;
		if (r < 8)
			return '0;
		if (r < 16)
			return coin_t'($urandom);
		if (r < 30)
			return coin_t'($urandom_range(1, MAX_TARGET));
		return coin_t'($urandom_range(1, hi));
	endfunction

	initial begin
		int   phase;
		int   len;
		int   k;
		int   phase_items;
		bit   mid_done;
		tgt_t tgt;

		sb = new();
		arst_n             = 1'b0;
		coin_if.valid      = 1'b0;
		coin_if.coin_value = '0;
		coin_if.last_coin  = 1'b0;
		cfg_if.valid       = 1'b0;
		cfg_if.data        = '0;
		res_if.ready       = 1'b0;
		coin_offering = 0;
		burst_left    = 0;
		target_writes = 0;
		rx_hold_req   = 0;
		rx_hold_left  = 0;
		rx_mode       = 0;
		rx_mode_left  = 0;
		rx_stall_left = 0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed sets ----
		// reset target 0, set of one zero coin: table rebuilt, zero coins
		send_coin('0, 1'b1);
		write_target(tgt_t'(MAX_TARGET));
		// only 1s: largest possible count
		send_coin(coin_t'(1), 1'b1);
		// empty set against a nonzero target: no solution
		send_coin('0, 1'b1);
		// coins past the table end, a zero in the middle, exact top coin
		send_coin(coin_t'(16'hFFFF), 1'b0);
		send_coin(coin_t'(1024), 1'b0);
		send_coin('0, 1'b0);
		send_coin(coin_t'(MAX_TARGET), 1'b1);
		write_target(tgt_t'(7));
		// even coins only, odd target; zero last coin still yields a result
		send_coin(coin_t'(2), 1'b0);
		send_coin(coin_t'(4), 1'b0);
		send_coin('0, 1'b1);
		// alternating bit patterns, then 3 + 4
		send_coin(coin_t'(16'hAAAA), 1'b0);
		send_coin(coin_t'(16'h5555), 1'b0);
		send_coin(coin_t'(3), 1'b0);
		send_coin(coin_t'(4), 1'b1);
		// target moved mid-set: 11 = 3 + 3 + 5 honored at the last coin
		send_coin(coin_t'(3), 1'b0);
		send_coin(coin_t'(5), 1'b0);
		write_target(tgt_t'(11));
		send_coin('0, 1'b1);
		// target 0 with real coins: zero coins
		write_target('0);
		send_coin(coin_t'(16'hFFFF), 1'b0);
		send_coin(coin_t'(7), 1'b1);

		// ---- random sets, a new target each phase (sometimes moved mid-set), extremes first and last ----
		for (phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				0: tgt = tgt_t'(MAX_TARGET);
				1: tgt = '0;
				2: tgt = tgt_t'(1);
				NUM_PHASES - 1: tgt = tgt_t'(MAX_TARGET);
				default: tgt = tgt_t'($urandom_range(0, MAX_TARGET));
			endcase
			write_target(tgt);
			// long result hold-off while single-coin sets keep arriving
			if (phase == HOLD_PHASE)
				rx_hold_req = RX_HOLD_CYCLES;
			mid_done    = 0;
			phase_items = 0;
			while (phase_items < ITEMS_PER_PHASE) begin
				len = (phase == HOLD_PHASE) ? 1 : $urandom_range(1, 5);
				for (k = 0; k < len; k++) begin
					// occasional target change inside an open set
					if (k == 1 && !mid_done && $urandom_range(0, 3) == 0) begin
						mid_done = 1;
						tgt = tgt_t'($urandom_range(0, MAX_TARGET));
						write_target(tgt);
					end
					send_coin(pick_coin(tgt), k == len - 1);
					phase_items++;
				end
			end
		end

		settle_block();

		$display("Covered %0d coin beats in %0d sets across %0d target writes, incl. 0 and 1023,",
			sb.coins_seen, sb.sets_done, target_writes);
		$display("mid-set target moves and a long result hold-off; %0d results, %0d errors.",
			sb.results_seen, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== files.f =====
src/mcc_pkg.sv
src/mcc_if.sv
src/mcc_ram.sv
src/min_coin_change_dp.sv
dv/min_coin_change_dp_tb.sv
